@@ rtl/core/asbs_pkg.sv @@
// Shared types, constants and the sine table generator for the additive sine bank.
// No dependencies; used by every module of the block.
package asbs_pkg;

    localparam int PARTIALS_DEF        = 256;
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int PHASE_BITS_DEF      = 32;

    localparam logic [31:0] BASE_INC_RESET = 32'd53687091;
    localparam logic [31:0] STEP_INC_RESET = 32'd8053064;
    localparam logic [8:0]  PARTIALS_RESET = 9'd256;

    localparam logic [1:0] CFG_BASE_INC = 2'd0;
    localparam logic [1:0] CFG_STEP_INC = 2'd1;
    localparam logic [1:0] CFG_PARTIALS = 2'd2;

    localparam longint SINE_SCALE    = 64'sd32767;
    localparam longint HALF_PI_Q30   = 64'sd1686629713;
    localparam longint ONE_Q30       = 64'sd1073741824;
    localparam longint ROUND_BIAS    = 64'sd16383;
    localparam longint POS_CLIP_LIM  = 64'sd1073709056;
    localparam longint NEG_CLIP_LIM  = 64'sd1073741823;

    // Taylor divisors ONE_Q30 * (2n) * (2n + 1) for n = 1 .. 10
    localparam longint TAYLOR_DIV_1  = ONE_Q30 * 6;
    localparam longint TAYLOR_DIV_2  = ONE_Q30 * 20;
    localparam longint TAYLOR_DIV_3  = ONE_Q30 * 42;
    localparam longint TAYLOR_DIV_4  = ONE_Q30 * 72;
    localparam longint TAYLOR_DIV_5  = ONE_Q30 * 110;
    localparam longint TAYLOR_DIV_6  = ONE_Q30 * 156;
    localparam longint TAYLOR_DIV_7  = ONE_Q30 * 210;
    localparam longint TAYLOR_DIV_8  = ONE_Q30 * 272;
    localparam longint TAYLOR_DIV_9  = ONE_Q30 * 342;
    localparam longint TAYLOR_DIV_10 = ONE_Q30 * 420;

    localparam logic [16:0] GAIN_ONE   = 17'd16380;
    localparam logic [16:0] GAIN_TWO   = 17'd32760;
    localparam logic [16:0] GAIN_THREE = 17'd49140;

    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_GEN     = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_ROUND1,
        ST_ROUND2
    } t_state;

    typedef struct packed {
        logic clear;
        logic issue;
        logic round;
    } t_mac_ctl;

    typedef struct packed {
        logic               busy;
        logic signed [15:0] sample;
        logic               clipped;
    } t_mac_stat;

    // first-quadrant sine in Q30 Taylor form, scaled to 32767
    function automatic longint quarter_sine(longint m, int bits);
        longint quarter;
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint v;
        quarter = longint'(1) << (bits - 2);
        if (m >= quarter) begin
            return SINE_SCALE;
        end
        x = (m * HALF_PI_Q30) >> (bits - 2);
        x2 = (x * x) / ONE_Q30;
        term = x;
        sum = x;
        term = -(term * x2) / TAYLOR_DIV_1;
        sum = sum + term;
        term = -(term * x2) / TAYLOR_DIV_2;
        sum = sum + term;
        term = -(term * x2) / TAYLOR_DIV_3;
        sum = sum + term;
        term = -(term * x2) / TAYLOR_DIV_4;
        sum = sum + term;
        term = -(term * x2) / TAYLOR_DIV_5;
        sum = sum + term;
        term = -(term * x2) / TAYLOR_DIV_6;
        sum = sum + term;
        term = -(term * x2) / TAYLOR_DIV_7;
        sum = sum + term;
        term = -(term * x2) / TAYLOR_DIV_8;
        sum = sum + term;
        term = -(term * x2) / TAYLOR_DIV_9;
        sum = sum + term;
        term = -(term * x2) / TAYLOR_DIV_10;
        sum = sum + term;
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > ONE_Q30) begin
            sum = ONE_Q30;
        end
        v = (sum * SINE_SCALE + ONE_Q30 / 2) / ONE_Q30;
        if (v > SINE_SCALE) begin
            v = SINE_SCALE;
        end
        return v;
    endfunction

    function automatic logic signed [15:0] sine_entry(int k, int bits);
        longint quarter;
        longint quad;
        longint r;
        longint s;
        quarter = longint'(1) << (bits - 2);
        quad = longint'(k) >> (bits - 2);
        r = longint'(k) & (quarter - 1);
        s = quad[0] ? quarter_sine(quarter - r, bits) : quarter_sine(r, bits);
        return quad[1] ? 16'(-s) : 16'(s);
    endfunction

endpackage

@@ rtl/core/asbs_in_if.sv @@
// Input channel of the additive sine bank: command item with valid/ready.
// No dependencies.
interface asbs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] partial_index;
    logic [1:0] amplitude_code;

    modport source(output valid, output cmd, output partial_index, output amplitude_code,
                   input ready);
    modport sink(input valid, input cmd, input partial_index, input amplitude_code,
                 output ready);
endinterface

@@ rtl/core/asbs_out_if.sv @@
// Output channel of the additive sine bank: sample item with valid/ready.
// No dependencies.
interface asbs_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               clipped;

    modport source(output valid, output sample, output clipped, input ready);
    modport sink(input valid, input sample, input clipped, output ready);
endinterface

@@ rtl/core/asbs_amp_store.sv @@
// Amplitude store: one-write, one-read synchronous memory of 2-bit codes.
// Depends on asbs_pkg (PARTIALS_DEF) for the default depth.
module asbs_amp_store #(
    parameter int DEPTH  = asbs_pkg::PARTIALS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [1:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [1:0]        o_rdata
);
    logic [1:0] r_mem [DEPTH];
    logic [1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/asbs_sine_rom.sv @@
// Sine table ROM with registered read, built at elaboration.
// Depends on asbs_pkg (sine_entry).
module asbs_sine_rom #(
    parameter int SINE_TABLE_BITS = asbs_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic [SINE_TABLE_BITS-1:0] i_idx,
    output logic signed [15:0]         o_sine
);
    import asbs_pkg::*;

    localparam int TABLE_SIZE = 1 << SINE_TABLE_BITS;

    logic signed [15:0] w_rom [TABLE_SIZE];
    logic signed [15:0] r_sine;

    for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_rom
        assign w_rom[k] = sine_entry(k, SINE_TABLE_BITS);
    end

    always_ff @(posedge i_clk) begin
        r_sine <= w_rom[i_idx];
    end

    assign o_sine = r_sine;
endmodule

@@ rtl/core/asbs_mac.sv @@
// Multiply-accumulate of partial terms, then round by 1/32767 and saturate.
// Depends on asbs_pkg (control/status structs, rounding constants).
module asbs_mac #(
    parameter int PARTIALS = asbs_pkg::PARTIALS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  asbs_pkg::t_mac_ctl   i_ctl,
    input  logic [1:0]           i_amp,
    input  logic signed [15:0]   i_sine,
    output asbs_pkg::t_mac_stat  o_stat
);
    import asbs_pkg::*;

    localparam int ACC_W = 33 + ((PARTIALS > 1) ? $clog2(PARTIALS) : 0);

    logic                    r_v1;
    logic                    r_v2;
    logic signed [31:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_neg;
    logic [ACC_W-1:0]        r_mag;

    logic signed [16:0]      w_gain;
    logic signed [32:0]      w_prod;
    logic signed [ACC_W-1:0] w_abs;
    logic                    w_clip;
    logic [30:0]             w_qsum;
    logic signed [15:0]      w_q;

    always_comb begin
        unique case (i_amp)
            2'd0:    w_gain = '0;
            2'd1:    w_gain = signed'(GAIN_ONE);
            2'd2:    w_gain = signed'(GAIN_TWO);
            default: w_gain = signed'(GAIN_THREE);
        endcase
    end

    assign w_prod = w_gain * i_sine;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= signed'(w_prod[31:0]);
        end
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_ctl.round) begin
            r_neg <= r_acc[ACC_W-1];
            r_mag <= $unsigned(w_abs) + ACC_W'(ROUND_BIAS);
        end
    end

    assign w_abs = r_acc[ACC_W-1] ? -r_acc : r_acc;

    // below the clip limits the biased magnitude fits 30 bits; divide by 2^15-1
    assign w_clip = r_neg ? (r_mag >= ACC_W'(NEG_CLIP_LIM)) : (r_mag >= ACC_W'(POS_CLIP_LIM));
    assign w_qsum = {1'b0, r_mag[29:0]} + 31'(r_mag[29:15]) + 31'd1;
    assign w_q    = signed'(w_qsum[30:15]);

    always_comb begin
        o_stat.busy    = r_v1 | r_v2;
        o_stat.clipped = w_clip;
        if (w_clip) begin
            o_stat.sample = r_neg ? SAMPLE_MIN : SAMPLE_MAX;
        end else begin
            o_stat.sample = r_neg ? -w_q : w_q;
        end
    end
endmodule

@@ rtl/core/additive_sine_bank_synth_top.sv @@
// Additive sine oscillator bank: top level with sequencer, phase registers,
// configuration and output register. Depends on asbs_pkg, asbs_in_if, asbs_out_if,
// asbs_amp_store, asbs_sine_rom and asbs_mac.
//
// Usage:
//   i_in carries command items (load amplitude, generate sample, restart time).
//   o_out carries one sample item per generate command; the others give none.
//   Config must be written through i_cfg_we/i_cfg_index/i_cfg_data only while
//   idle; the block does not enforce this. Load and restart items leave the
//   block idle and ready for the next item. A generate item steps one partial
//   per cycle, as the single read port of each memory and the shared multiplier
//   allow, through the amplitude store and the sine ROM over N partials,
//   N = min(partials_in_use, PARTIALS), then drains and rounds; the next item is
//   taken once the sample is registered and the sequencer is back to idle.
//   After reset the amplitude store is cleared, one entry a cycle, through all
//   PARTIALS entries; config writes are taken meanwhile, items are not.
//   The result waits in an output register; new items are still accepted while
//   it waits. A finished sample that finds that register full holds the
//   sequencer until the receiver takes the waiting item.
module additive_sine_bank_synth_top #(
    parameter int PARTIALS        = asbs_pkg::PARTIALS_DEF,
    parameter int SINE_TABLE_BITS = asbs_pkg::SINE_TABLE_BITS_DEF,
    parameter int PHASE_BITS      = asbs_pkg::PHASE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    asbs_in_if.sink     i_in,
    asbs_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import asbs_pkg::*;

    localparam int IDX_W = (PARTIALS > 1) ? $clog2(PARTIALS) : 1;
    localparam int CNT_W = $clog2(PARTIALS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PARTIALS - 1);

    t_state                r_state;
    t_state                n_state;
    logic [IDX_W-1:0]      r_j;
    logic [CNT_W-1:0]      r_left;
    logic [PHASE_BITS-1:0] r_base_inc;
    logic [PHASE_BITS-1:0] r_step_inc;
    logic [8:0]            r_partials;
    logic [PHASE_BITS-1:0] r_base_phase;
    logic [PHASE_BITS-1:0] r_step_phase;
    logic [PHASE_BITS-1:0] r_ph;
    logic                  r_out_valid;
    logic signed [15:0]    r_sample;
    logic                  r_clipped;

    t_cmd                  w_cmd;
    logic                  w_in_fire;
    logic                  w_gen;
    logic                  w_restart;
    logic                  w_load;
    logic [CNT_W-1:0]      w_count;
    logic                  w_last;
    logic                  w_slot_free;
    logic                  w_out_load;
    logic                  w_amp_we;
    logic [IDX_W-1:0]      w_amp_waddr;
    logic [1:0]            w_amp_wdata;
    logic [1:0]            w_amp_rdata;
    logic signed [15:0]    w_sine;
    t_mac_ctl              w_mac_ctl;
    t_mac_stat             w_mac_stat;

    assign w_cmd     = t_cmd'(i_in.cmd);
    assign w_in_fire = i_in.valid && i_in.ready;

    always_comb begin
        w_gen     = 1'b0;
        w_restart = 1'b0;
        w_load    = 1'b0;
        unique case (w_cmd)
            CMD_LOAD:    w_load    = w_in_fire;
            CMD_GEN:     w_gen     = w_in_fire;
            CMD_RESTART: w_restart = w_in_fire;
            default: ;
        endcase
    end

    assign w_count = (int'(r_partials) > PARTIALS) ? CNT_W'(PARTIALS) : CNT_W'(r_partials);
    assign w_last  = (r_left == CNT_W'(1));
    assign w_slot_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_j == LAST_IDX) n_state = ST_IDLE;
            ST_IDLE:   if (w_gen) n_state = (w_count == '0) ? ST_DRAIN : ST_RUN;
            ST_RUN:    if (w_last) n_state = ST_DRAIN;
            ST_DRAIN:  if (!w_mac_stat.busy) n_state = ST_ROUND1;
            ST_ROUND1: n_state = ST_ROUND2;
            ST_ROUND2: if (w_slot_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready      = (r_state == ST_IDLE);
        w_mac_ctl.clear = w_gen;
        w_mac_ctl.issue = (r_state == ST_RUN);
        w_mac_ctl.round = (r_state == ST_ROUND1);
        w_out_load      = (r_state == ST_ROUND2) && w_slot_free;
        w_amp_we        = 1'b0;
        w_amp_waddr     = r_j;
        w_amp_wdata     = 2'd0;
        if (r_state == ST_CLEAR) begin
            w_amp_we = 1'b1;
        end else if (w_load && (int'(i_in.partial_index) < PARTIALS)) begin
            w_amp_we    = 1'b1;
            w_amp_waddr = IDX_W'(i_in.partial_index);
            w_amp_wdata = i_in.amplitude_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_j          <= '0;
            r_left       <= '0;
            r_base_phase <= '0;
            r_step_phase <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_j <= (r_j == LAST_IDX) ? '0 : r_j + IDX_W'(1);
            end else if (w_gen) begin
                r_j    <= '0;
                r_left <= w_count;
            end else if (r_state == ST_RUN) begin
                r_j    <= r_j + IDX_W'(1);
                r_left <= r_left - CNT_W'(1);
            end
            if (w_restart) begin
                r_base_phase <= '0;
                r_step_phase <= '0;
            end else if ((r_state == ST_RUN && w_last) || (w_gen && w_count == '0)) begin
                r_base_phase <= r_base_phase + r_base_inc;
                r_step_phase <= r_step_phase + r_step_inc;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_inc <= PHASE_BITS'(BASE_INC_RESET);
            r_step_inc <= PHASE_BITS'(STEP_INC_RESET);
            r_partials <= PARTIALS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BASE_INC: r_base_inc <= PHASE_BITS'(i_cfg_data);
                CFG_STEP_INC: r_step_inc <= PHASE_BITS'(i_cfg_data);
                CFG_PARTIALS: r_partials <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_gen) begin
            r_ph <= r_base_phase;
        end else if (r_state == ST_RUN) begin
            r_ph <= r_ph + r_step_phase;
        end
        if (w_out_load) begin
            r_sample  <= w_mac_stat.sample;
            r_clipped <= w_mac_stat.clipped;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.sample  = r_sample;
    assign o_out.clipped = r_clipped;

    asbs_amp_store #(
        .DEPTH (PARTIALS)
    ) u_amp_store (
        .i_clk   (i_clk),
        .i_we    (w_amp_we),
        .i_waddr (w_amp_waddr),
        .i_wdata (w_amp_wdata),
        .i_raddr (r_j),
        .o_rdata (w_amp_rdata)
    );

    asbs_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_idx  (r_ph[PHASE_BITS-1 -: SINE_TABLE_BITS]),
        .o_sine (w_sine)
    );

    asbs_mac #(
        .PARTIALS (PARTIALS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_amp   (w_amp_rdata),
        .i_sine  (w_sine),
        .o_stat  (w_mac_stat)
    );

`ifndef SYNTHESIS
    a_gen_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_gen && w_count != '0) |=> (r_state == ST_RUN))
        else $error("generate item did not start the partial sweep");

    a_round_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND1) |-> !w_mac_stat.busy)
        else $error("rounding started with terms still in the pipeline");

    a_store_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_amp_we |-> (r_state == ST_CLEAR || r_state == ST_IDLE))
        else $error("amplitude store written during a sweep");

    a_run_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_left != '0))
        else $error("sweep running with no partials left");
`endif
endmodule
